>>> rtl/hbfd_pkg.sv
// Shared types and constants for the heartbeat failure detector.
// Used by every module of the block; depends on nothing.
package hbfd_pkg;

  localparam int PEER_W = 4;
  localparam int AGE_W  = 16;
  localparam int CNT_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Configuration reset values.
  localparam logic [PEER_W-1:0] OWN_ID_RST     = 4'd0;
  localparam logic [CNT_W-1:0]  PEER_COUNT_RST = 5'd4;
  localparam logic [AGE_W-1:0]  HB_PERIOD_RST  = 16'd2;
  localparam logic [AGE_W-1:0]  TIMEOUT_RST    = 16'd6;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_OWN_ID     = 2'd0,
    REG_PEER_COUNT = 2'd1,
    REG_HB_PERIOD  = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  // Event kinds of a request.
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_SUSPICION = 2'd2,
    CMD_ALIVE     = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic {
    KIND_HEARTBEAT = 1'b0,
    KIND_SUSPICION = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PEER_W-1:0] source_peer;
    logic [PEER_W-1:0] subject_peer;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [PEER_W-1:0] peer;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [PEER_W-1:0] own_id;
    logic [CNT_W-1:0]  peer_count;
    logic [AGE_W-1:0]  heartbeat_period;
    logic [AGE_W-1:0]  timeout_ticks;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic msg_apply;
    logic tick_start;
    logic scan_step;
    logic flush;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic flush_done;
  } dp_status_t;

endpackage

>>> rtl/hbfd_regs.sv
// Configuration register file of the heartbeat failure detector.
// Depends on hbfd_pkg for the register layout and reset values.
module hbfd_regs
  import hbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id           <= OWN_ID_RST;
      cfg.peer_count       <= PEER_COUNT_RST;
      cfg.heartbeat_period <= HB_PERIOD_RST;
      cfg.timeout_ticks    <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_OWN_ID:     cfg.own_id           <= pwdata[PEER_W-1:0];
        REG_PEER_COUNT: cfg.peer_count       <= pwdata[CNT_W-1:0];
        REG_HB_PERIOD:  cfg.heartbeat_period <= pwdata[AGE_W-1:0];
        REG_TIMEOUT:    cfg.timeout_ticks    <= pwdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OWN_ID:     prdata = 32'(cfg.own_id);
      REG_PEER_COUNT: prdata = 32'(cfg.peer_count);
      REG_HB_PERIOD:  prdata = 32'(cfg.heartbeat_period);
      REG_TIMEOUT:    prdata = 32'(cfg.timeout_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/hbfd_ctrl.sv
// Controller state machine of the heartbeat failure detector.
// Depends on hbfd_pkg for the state, command and status types.
module hbfd_ctrl
  import hbfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_cmd,
  input  dp_status_t status,
  output logic       req_stall,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_stall      = 1'b1;
    cmd            = '0;
    accept         = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall      = 1'b0;
        accept         = req_valid;
        cmd.tick_start = accept && (cmd_t'(req_cmd) == CMD_TICK);
        cmd.msg_apply  = accept && (cmd_t'(req_cmd) != CMD_TICK);
        if (cmd.tick_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (status.flush_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/hbfd_dp.sv
// Datapath of the heartbeat failure detector: peer age memory, suspected
// flags, send timer, pending result and output register. Depends on hbfd_pkg.
module hbfd_dp
  import hbfd_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  cfg_t       cfg,
  input  req_t       req,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output rsp_t       rsp,
  output dp_status_t status
);

  localparam int IDX_W = (MAX_PEERS > 2) ? $clog2(MAX_PEERS) : 1;
  localparam int CW    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);
  localparam logic [CW-1:0]    MAX_CW   = CW'(MAX_PEERS);

  logic [AGE_W-1:0]     age_mem [MAX_PEERS];
  logic [MAX_PEERS-1:0] age_vld;
  logic [MAX_PEERS-1:0] susp;
  logic [AGE_W-1:0]     rd_data;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     scan_idx;
  logic [AGE_W-1:0]     send_timer;

  logic                 pend_valid;
  logic                 pend_kind;
  logic [PEER_W-1:0]    pend_peer;

  logic [AGE_W-1:0]     age_cur, age_new, timer_inc;
  logic                 hb_due;
  logic                 slot_active, slot_own, found;
  logic                 out_free, blocked, advance;
  logic                 load_scan, load_flush;

  logic [PEER_W-1:0]    msg_peer;
  logic [IDX_W-1:0]     msg_idx;
  logic                 msg_ok, msg_hb, msg_susp, msg_alive;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [AGE_W-1:0]     wdata;

  // Message decode: suspicions name the subject, other messages the sender.
  always_comb begin
    msg_hb    = cmd.msg_apply && (cmd_t'(req.cmd) == CMD_HEARTBEAT);
    msg_susp  = cmd.msg_apply && (cmd_t'(req.cmd) == CMD_SUSPICION);
    msg_alive = cmd.msg_apply && (cmd_t'(req.cmd) == CMD_ALIVE);
    msg_peer  = msg_susp ? req.subject_peer : req.source_peer;
    msg_idx   = IDX_W'(msg_peer);
    msg_ok    = (CW'(msg_peer) < CW'(cfg.peer_count)) && (CW'(msg_peer) < MAX_CW);
  end

  // Scan of one peer slot per cycle while the walk is not blocked on a result.
  always_comb begin
    age_cur     = rd_vld ? rd_data : '0;
    age_new     = (age_cur == AGE_MAX) ? age_cur : age_cur + AGE_W'(1);
    slot_active = CW'(scan_idx) < CW'(cfg.peer_count);
    slot_own    = CW'(scan_idx) == CW'(cfg.own_id);
    found       = slot_active && !slot_own && !susp[scan_idx] &&
                  (age_new > cfg.timeout_ticks);
    out_free    = !rsp_valid || !rsp_stall;
    blocked     = found && pend_valid && !out_free;
    advance     = cmd.scan_step && !blocked;
    load_scan   = advance && found && pend_valid;
    load_flush  = cmd.flush && pend_valid && out_free;

    status.scan_done  = advance && (scan_idx == LAST_IDX);
    status.flush_done = cmd.flush && (!pend_valid || out_free);

    timer_inc = (send_timer == AGE_MAX) ? send_timer : send_timer + AGE_W'(1);
    hb_due    = timer_inc >= cfg.heartbeat_period;

    if (cmd.tick_start) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = scan_idx + IDX_W'(1);
    end else begin
      rd_addr = scan_idx;
    end

    we    = advance || (msg_hb && msg_ok);
    waddr = advance ? scan_idx : msg_idx;
    wdata = advance ? age_new : '0;
  end

  // Age memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      age_mem[waddr] <= wdata;
    end
    rd_data <= age_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_vld    <= '0;
      rd_vld     <= 1'b0;
      susp       <= '0;
      send_timer <= '0;
      scan_idx   <= '0;
    end else begin
      rd_vld <= age_vld[rd_addr];
      if (we) begin
        age_vld[waddr] <= 1'b1;
      end
      if (cmd.tick_start) begin
        scan_idx   <= '0;
        send_timer <= hb_due ? '0 : timer_inc;
      end else if (advance) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (advance && found) begin
        susp[scan_idx] <= 1'b1;
      end
      if (msg_ok && (msg_hb || msg_alive)) begin
        susp[msg_idx] <= 1'b0;
      end
      if (msg_ok && msg_susp) begin
        susp[msg_idx] <= 1'b1;
      end
    end
  end

  // The newest result waits here until the next one shows whether it is last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.tick_start) begin
      pend_valid <= hb_due;
    end else if (advance && found) begin
      pend_valid <= 1'b1;
    end else if (load_flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      pend_kind <= KIND_HEARTBEAT;
      pend_peer <= '0;
    end else if (advance && found) begin
      pend_kind <= KIND_SUSPICION;
      pend_peer <= PEER_W'(scan_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_scan || load_flush) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_scan || load_flush) begin
      rsp.kind <= pend_kind;
      rsp.peer <= pend_peer;
      rsp.last <= load_flush;
    end
  end

endmodule

>>> rtl/heartbeat_failure_detector.sv
// Heartbeat failure detector: a per-peer liveness monitor.
// Request channel (req_valid, req_stall, req) carries events; result channel
// (rsp_valid, rsp_stall, rsp) carries heartbeat and suspicion broadcasts.
// A request is taken at an edge with its valid high and stall low.
// Heartbeat, suspicion and alive requests update the peer table in the cycle
// they are taken and produce no result; the next request can follow at once.
// A tick request walks the age memory one peer slot per cycle while it does
// not pause, all MAX_PEERS slots, and then hands off its last pending result
// in a flush state before the controller returns to idle.
// Results leave through an output register; the final result of a tick has
// last set. A result is held stable while rsp_stall is high, and the walk
// pauses on a slot when a new result finds the pending register full and the
// output register stalled; a new request can be taken while a result waits.
// Reset (rst, synchronous, active high) clears all ages, flags and the send
// timer, loads the configuration defaults and empties the output register.
// Configuration registers are written over the APB port, at byte addresses
// 0, 4, 8 and 12, by the user only while idle; the block does not enforce it.
module heartbeat_failure_detector
  import hbfd_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register file for own id, group size, heartbeat period and timeout.
  hbfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller takes requests only while idle and sequences the walk.
  hbfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  // The datapath holds the peer table and produces the results.
  hbfd_dp #(
    .MAX_PEERS (MAX_PEERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .status    (status)
  );

endmodule
